/* design/tmbt_pkg.sv */
// tmbt_pkg: shared types, mixing coefficients and reciprocal constants for the thruster mixer
`timescale 1ns / 1ps
package tmbt_pkg;

  // fixed field widths
  localparam int unsigned AXIS_W   = 16;
  localparam int unsigned BTN_W    = 17;
  localparam int unsigned GAIN_W   = 4;
  localparam int unsigned THR_NUM  = 6;
  localparam int unsigned AXIS_NUM = 5;
  localparam int unsigned IDX_W    = 3;

  // gain limits in tenths
  localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd5;
  localparam logic [GAIN_W-1:0] GAIN_MIN   = 4'd1;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 4'd10;

  // buttons that step the gain
  localparam int unsigned BTN_GAIN_DN = 4;
  localparam int unsigned BTN_GAIN_UP = 5;

  // opcodes
  localparam logic OP_VELOCITY = 1'b0;
  localparam logic OP_BUTTONS  = 1'b1;

  // coefficient codes
  typedef logic [1:0] coef_t;
  localparam coef_t C_ZERO = 2'b00;
  localparam coef_t C_POS  = 2'b01;
  localparam coef_t C_NEG  = 2'b11;

  // one column of coefficients: [0] surge, [1] sway, [2] heave, [3] roll, [4] yaw
  typedef coef_t [AXIS_NUM-1:0] coef_col_t;

  // reciprocal scaling: floor(m / (10 * n)) = (m * recip(n)) >> RECIP_SH
  localparam int unsigned RECIP_SH = 32;
  localparam int unsigned RECIP_W  = 29;
  typedef logic [RECIP_W-1:0] recip_t;

  typedef struct packed {
    logic                     op;
    logic signed [AXIS_W-1:0] surge;
    logic signed [AXIS_W-1:0] sway;
    logic signed [AXIS_W-1:0] heave;
    logic signed [AXIS_W-1:0] roll_axis;
    logic signed [AXIS_W-1:0] yaw_axis;
    logic [BTN_W-1:0]         buttons;
  } tmbt_in_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] thrust_one;
    logic signed [AXIS_W-1:0] thrust_two;
    logic signed [AXIS_W-1:0] thrust_three;
    logic signed [AXIS_W-1:0] thrust_four;
    logic signed [AXIS_W-1:0] thrust_five;
    logic signed [AXIS_W-1:0] thrust_six;
    logic [BTN_W-1:0]         toggles;
    logic [GAIN_W-1:0]        gain_tenths;
  } tmbt_out_t;

  // controller to datapath
  typedef struct packed {
    logic             take_btn;
    logic             take_vel;
    logic             issue;
    logic [IDX_W-1:0] idx;
    logic             load_out;
  } tmbt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic out_free;
  } tmbt_sts_t;

  // coefficient column for one thruster
  function automatic coef_col_t coef_col(input logic [IDX_W-1:0] thr);
    coef_col_t col;
    col = '{default: C_ZERO};
    unique case (thr)
      3'd0: col = '{C_NEG, C_ZERO, C_ZERO, C_NEG, C_POS};
      3'd1: col = '{C_ZERO, C_NEG, C_NEG, C_ZERO, C_ZERO};
      3'd2: col = '{C_NEG, C_ZERO, C_ZERO, C_POS, C_POS};
      3'd3: col = '{C_POS, C_ZERO, C_ZERO, C_POS, C_POS};
      3'd4: col = '{C_ZERO, C_NEG, C_POS, C_ZERO, C_ZERO};
      3'd5: col = '{C_POS, C_ZERO, C_ZERO, C_NEG, C_POS};
      default: col = '{default: C_ZERO};
    endcase
    return col;
  endfunction

  // ceil(2^32 / (10 * n)), zero when no term contributes
  function automatic recip_t recip(input logic [1:0] n);
    recip_t r;
    r = '0;
    unique case (n)
      2'd0: r = 29'd0;
      2'd1: r = 29'd429496730;
      2'd2: r = 29'd214748365;
      2'd3: r = 29'd143165577;
      default: r = 29'd0;
    endcase
    return r;
  endfunction

endpackage

/* design/tmbt_chan_if.sv */
// tmbt_chan_if: valid/ready channel carrying one word of payload type T
`timescale 1ns / 1ps
interface tmbt_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/thruster_mix_and_button_toggle.sv */
// thruster_mix_and_button_toggle: top level joining controller and datapath
// a button word updates toggles and gain on acceptance, then the output word is loaded
// in ST_DONE once the output register is free; a velocity word sends six thrusters into
// a 3-stage pipeline (sum, gain multiply, reciprocal multiply) one per cycle, drains in
// ST_DRAIN and is loaded the same way; the next word is taken only after that load
// synchronous active-low reset: toggles and release flags cleared, gain 5, drives 0
`timescale 1ns / 1ps
module thruster_mix_and_button_toggle #(
  parameter int unsigned BUTTON_COUNT = 17
) (
  input logic       clk,
  input logic       rst_n,
  tmbt_chan_if.sink   in_if,
  tmbt_chan_if.source out_if
);

  localparam int unsigned LATCH_W =
    (BUTTON_COUNT < tmbt_pkg::BTN_W) ? BUTTON_COUNT : tmbt_pkg::BTN_W;

  tmbt_pkg::tmbt_cmd_t cmd;
  tmbt_pkg::tmbt_sts_t sts;
  tmbt_pkg::tmbt_in_t  in_word;
  tmbt_pkg::tmbt_out_t out_word;

  assign in_word     = in_if.data;
  assign out_if.data = out_word;

  // sequencer
  tmbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_op    (in_word.op),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  tmbt_dp #(
    .LATCH_W (LATCH_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .out_data  (out_word)
  );

endmodule

/* design/tmbt_ctrl.sv */
// tmbt_ctrl: sequencer that steps the six thrusters through the datapath pipeline
`timescale 1ns / 1ps
module tmbt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  input  tmbt_pkg::tmbt_sts_t sts,
  output tmbt_pkg::tmbt_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MIX   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [tmbt_pkg::IDX_W-1:0] LAST_THR =
    tmbt_pkg::IDX_W'(tmbt_pkg::THR_NUM - 1);

  logic [1:0]                   state_r, state_nxt;
  logic [tmbt_pkg::IDX_W-1:0]   thr_r, thr_nxt;
  logic                         accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    thr_nxt      = thr_r;
    cmd          = '0;
    cmd.idx      = thr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == tmbt_pkg::OP_BUTTONS) begin
            cmd.take_btn = 1'b1;
            state_nxt    = ST_DONE;
          end else begin
            cmd.take_vel = 1'b1;
            thr_nxt      = '0;
            state_nxt    = ST_MIX;
          end
        end
      end
      ST_MIX: begin
        cmd.issue = 1'b1;
        thr_nxt   = thr_r + 1'b1;
        if (thr_r == LAST_THR) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      thr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      thr_r   <= thr_nxt;
    end
  end

endmodule

/* design/tmbt_dp.sv */
// tmbt_dp: button latches, gain, thruster mixing pipeline and output register
`timescale 1ns / 1ps
module tmbt_dp #(
  parameter int unsigned LATCH_W = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tmbt_pkg::tmbt_in_t   in_data,
  input  tmbt_pkg::tmbt_cmd_t  cmd,
  output tmbt_pkg::tmbt_sts_t  sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output tmbt_pkg::tmbt_out_t  out_data
);

  localparam int unsigned AW    = tmbt_pkg::AXIS_W;
  localparam int unsigned IW    = tmbt_pkg::IDX_W;
  localparam int unsigned SUM_W = AW + 2;
  localparam int unsigned MAG_W = AW + 1;
  localparam int unsigned PRD_W = MAG_W + 3;
  localparam int unsigned QPW   = PRD_W + tmbt_pkg::RECIP_W;

  // button and gain state
  logic [LATCH_W-1:0]             toggle_r, toggle_nxt;
  logic [LATCH_W-1:0]             seen_r, seen_nxt;
  logic [tmbt_pkg::GAIN_W-1:0]    gain_r, gain_nxt, gain_mid;
  logic [LATCH_W-1:0]             levels, hits;

  // captured axes and thruster drives
  logic signed [AW-1:0]           axes_r [tmbt_pkg::AXIS_NUM];
  logic signed [AW-1:0]           thr_r [tmbt_pkg::THR_NUM];

  // pipeline registers
  logic                           va_r, vb_r, vc_r;
  logic [IW-1:0]                  idxa_r, idxb_r, idxc_r;
  logic                           nega_r, negb_r, negc_r;
  logic [1:0]                     cnta_r, cntb_r;
  logic [MAG_W-1:0]               maga_r;
  logic [PRD_W-1:0]               prodb_r;
  logic [MAG_W-1:0]               qc_r;

  logic signed [SUM_W-1:0]        sum_a;
  logic [SUM_W-1:0]               abs_a;
  logic [1:0]                     cnt_a;
  tmbt_pkg::coef_col_t            col_a;
  logic [QPW-1:0]                 qprod;
  logic [MAG_W-1:0]               qneg;
  logic signed [AW-1:0]           drive_d;

  logic                           out_valid_r;
  tmbt_pkg::tmbt_out_t            out_data_r;
  logic [tmbt_pkg::BTN_W-1:0]     toggles_full;

  // button scan: arm on release, toggle on an armed press
  assign levels     = in_data.buttons[LATCH_W-1:0];
  assign hits       = levels & seen_r;
  assign toggle_nxt = toggle_r ^ hits;
  assign seen_nxt   = ~levels;

  // gain steps: down button first, then up button, each clamped
  always_comb begin
    gain_mid = gain_r;
    if (hits[tmbt_pkg::BTN_GAIN_DN]) begin
      gain_mid = (gain_r <= 4'd2) ? tmbt_pkg::GAIN_MIN : gain_r - 1'b1;
    end
    gain_nxt = gain_mid;
    if (hits[tmbt_pkg::BTN_GAIN_UP]) begin
      gain_nxt = (gain_mid >= 4'd9) ? tmbt_pkg::GAIN_MAX : gain_mid + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      toggle_r <= '0;
      seen_r   <= '0;
      gain_r   <= tmbt_pkg::GAIN_RESET;
    end else if (cmd.take_btn) begin
      toggle_r <= toggle_nxt;
      seen_r   <= seen_nxt;
      gain_r   <= gain_nxt;
    end
  end

  // axis capture
  always_ff @(posedge clk) begin
    if (cmd.take_vel) begin
      axes_r[0] <= in_data.surge;
      axes_r[1] <= in_data.sway;
      axes_r[2] <= in_data.heave;
      axes_r[3] <= in_data.roll_axis;
      axes_r[4] <= in_data.yaw_axis;
    end
  end

  // stage a: signed sum and count of contributing terms
  always_comb begin
    col_a = tmbt_pkg::coef_col(cmd.idx);
    sum_a = '0;
    cnt_a = '0;
    for (int a = 0; a < tmbt_pkg::AXIS_NUM; a++) begin
      if (col_a[a] == tmbt_pkg::C_POS) begin
        sum_a = sum_a + SUM_W'(axes_r[a]);
      end else if (col_a[a] == tmbt_pkg::C_NEG) begin
        sum_a = sum_a - SUM_W'(axes_r[a]);
      end
      if (col_a[a] != tmbt_pkg::C_ZERO && axes_r[a] != '0) begin
        cnt_a = cnt_a + 1'b1;
      end
    end
    abs_a = sum_a[SUM_W-1] ? SUM_W'(-sum_a) : SUM_W'(sum_a);
  end

  // stage c input: scale by reciprocal of ten times the term count
  assign qprod = QPW'(prodb_r) * QPW'(tmbt_pkg::recip(cntb_r));

  // stage d: sign and saturation, positive magnitudes above 32767 clamp
  assign qneg = MAG_W'(-qc_r);
  always_comb begin
    if (negc_r) begin
      drive_d = AW'(qneg);
    end else if (qc_r[MAG_W-1:AW-1] != '0) begin
      drive_d = {1'b0, {(AW-1){1'b1}}};
    end else begin
      drive_d = AW'(qc_r);
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= cmd.issue;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    idxa_r  <= cmd.idx;
    maga_r  <= abs_a[MAG_W-1:0];
    nega_r  <= sum_a[SUM_W-1];
    cnta_r  <= cnt_a;
    idxb_r  <= idxa_r;
    prodb_r <= PRD_W'(PRD_W'(gain_r) * PRD_W'(maga_r));
    negb_r  <= nega_r;
    cntb_r  <= cnta_r;
    idxc_r  <= idxb_r;
    qc_r    <= qprod[QPW-1 -: MAG_W];
    negc_r  <= negb_r;
  end

  // thruster drive registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < tmbt_pkg::THR_NUM; t++) begin
        thr_r[t] <= '0;
      end
    end else if (vc_r) begin
      for (int t = 0; t < tmbt_pkg::THR_NUM; t++) begin
        if (idxc_r == IW'(t)) begin
          thr_r[t] <= drive_d;
        end
      end
    end
  end

  // toggles shown on the full button width
  always_comb begin
    toggles_full                = '0;
    toggles_full[LATCH_W-1:0]   = toggle_r;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.thrust_one   <= thr_r[0];
      out_data_r.thrust_two   <= thr_r[1];
      out_data_r.thrust_three <= thr_r[2];
      out_data_r.thrust_four  <= thr_r[3];
      out_data_r.thrust_five  <= thr_r[4];
      out_data_r.thrust_six   <= thr_r[5];
      out_data_r.toggles      <= toggles_full;
      out_data_r.gain_tenths  <= gain_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.busy     = va_r | vb_r | vc_r;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

/* dv/tb.sv */
// tb: self-checking bench for the thruster mixer with button toggles and shared gain
`timescale 1ns / 1ps
module tb;

  localparam int unsigned HOLD_AT   = 120;   // words seen before the long output stall
  localparam int unsigned HOLD_LEN  = 250;   // length of that stall in cycles
  localparam int unsigned DOG_LIMIT = 3000;  // cycles without any handshake
  localparam int unsigned TAIL      = 16;    // settle time after the last word

  logic clk;
  logic rst_n;

  tmbt_chan_if #(.T(tmbt_pkg::tmbt_in_t))  in_ch ();
  tmbt_chan_if #(.T(tmbt_pkg::tmbt_out_t)) out_ch ();

  thruster_mix_and_button_toggle u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // known levels before the first edge
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  // mixing coefficients, rows by axis: surge, sway, heave, roll, yaw
  int mix_tab [5][6] = '{
    '{ 1,  0,  1, 1,  0,  1},
    '{-1,  0,  1, 1,  0, -1},
    '{ 0, -1,  0, 0,  1,  0},
    '{ 0, -1,  0, 0, -1,  0},
    '{-1,  0, -1, 1,  0,  1}
  };

  string thr_name [6] = '{"thrust_one", "thrust_two", "thrust_three",
                          "thrust_four", "thrust_five", "thrust_six"};

  // mixer state as the block should hold it
  logic [tmbt_pkg::BTN_W-1:0]         latch_st;
  logic [tmbt_pkg::BTN_W-1:0]         armed_st;
  logic [tmbt_pkg::GAIN_W-1:0]        gain_st;
  logic signed [tmbt_pkg::AXIS_W-1:0] drive_st [6];

  tmbt_pkg::tmbt_in_t  stim_q [$];
  tmbt_pkg::tmbt_out_t due_words [$];

  logic        calm;
  int unsigned fail_cnt;
  int unsigned words_seen;
  int unsigned hold_left;
  logic        hold_done;
  int unsigned dog_cnt;

  initial begin
    latch_st   = '0;
    armed_st   = '0;
    gain_st    = tmbt_pkg::GAIN_RESET;
    for (int t = 0; t < 6; t++) drive_st[t] = '0;
    calm       = 1'b0;
    fail_cnt   = 0;
    words_seen = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    dog_cnt    = 0;
  end

  // append one word to the stimulus queue
  task automatic stim_put(input tmbt_pkg::tmbt_in_t w);
    stim_q = {stim_q, w};
  endtask

  // apply one accepted word to the mixer state and queue the word it must produce
  task automatic mix_word(input tmbt_pkg::tmbt_in_t w);
    longint              ax [5];
    longint              s;
    longint              n;
    longint              q;
    longint              term;
    tmbt_pkg::tmbt_out_t r;
    if (w.op == tmbt_pkg::OP_BUTTONS) begin
      for (int i = 0; i < tmbt_pkg::BTN_W; i++) begin
        if (!w.buttons[i]) begin
          armed_st[i] = 1'b1;
        end else if (armed_st[i]) begin
          armed_st[i] = 1'b0;
          latch_st[i] = ~latch_st[i];
          if (i == tmbt_pkg::BTN_GAIN_UP) begin
            gain_st = (gain_st >= 4'd9) ? tmbt_pkg::GAIN_MAX : gain_st + 4'd1;
          end else if (i == tmbt_pkg::BTN_GAIN_DN) begin
            gain_st = (gain_st <= 4'd2) ? tmbt_pkg::GAIN_MIN : gain_st - 4'd1;
          end
        end
      end
    end else begin
      ax[0] = $signed(w.surge);
      ax[1] = $signed(w.sway);
      ax[2] = $signed(w.heave);
      ax[3] = $signed(w.roll_axis);
      ax[4] = $signed(w.yaw_axis);
      for (int t = 0; t < 6; t++) begin
        s = 0;
        n = 0;
        for (int a = 0; a < 5; a++) begin
          term = ax[a] * mix_tab[a][t];
          s += term;
          if (term != 0) n++;
        end
        // integer division truncates toward zero
        if (s == 0 || n == 0) q = 0;
        else q = (longint'(gain_st) * s) / (10 * n);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        drive_st[t] = q[15:0];
      end
    end
    r.thrust_one   = drive_st[0];
    r.thrust_two   = drive_st[1];
    r.thrust_three = drive_st[2];
    r.thrust_four  = drive_st[3];
    r.thrust_five  = drive_st[4];
    r.thrust_six   = drive_st[5];
    r.toggles      = latch_st;
    r.gain_tenths  = gain_st;
    due_words = {due_words, r};
  endtask

  // compare one output word with the oldest expected one
  task automatic check_word(input tmbt_pkg::tmbt_out_t got);
    tmbt_pkg::tmbt_out_t                exp_w;
    logic signed [tmbt_pkg::AXIS_W-1:0] e_thr [6];
    logic signed [tmbt_pkg::AXIS_W-1:0] g_thr [6];
    words_seen++;
    if (due_words.size() == 0) begin
      $error("output word with nothing expected");
      fail_cnt++;
    end else begin
      exp_w = due_words.pop_front();
      e_thr = '{exp_w.thrust_one, exp_w.thrust_two, exp_w.thrust_three,
                exp_w.thrust_four, exp_w.thrust_five, exp_w.thrust_six};
      g_thr = '{got.thrust_one, got.thrust_two, got.thrust_three,
                got.thrust_four, got.thrust_five, got.thrust_six};
      for (int t = 0; t < 6; t++) begin
        if (g_thr[t] !== e_thr[t]) begin
          $error("%s expected %0d got %0d", thr_name[t], e_thr[t], g_thr[t]);
          fail_cnt++;
        end
      end
      if (got.toggles !== exp_w.toggles) begin
        $error("toggles expected %h got %h", exp_w.toggles, got.toggles);
        fail_cnt++;
      end
      if (got.gain_tenths !== exp_w.gain_tenths) begin
        $error("gain_tenths expected %0d got %0d", exp_w.gain_tenths, got.gain_tenths);
        fail_cnt++;
      end
    end
  endtask

  // input driver: predicts on acceptance, offers the next queued word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) mix_word(in_ch.data);
      if (!in_ch.valid || in_ch.ready) begin
        if (stim_q.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
          in_ch.data  <= stim_q.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: checks words, random back-pressure and one long stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_word(out_ch.data);
      if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && words_seen >= HOLD_AT) begin
        hold_done    <= 1'b1;
        hold_left    <= HOLD_LEN;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 36);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      dog_cnt <= 0;
    end else if (rst_n) begin
      dog_cnt <= dog_cnt + 1;
      if (dog_cnt >= DOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // random axis value, biased toward zero and full scale
  function automatic logic [tmbt_pkg::AXIS_W-1:0] rand_axis();
    logic [tmbt_pkg::AXIS_W-1:0] v;
    case ($urandom_range(7))
      0: v = '0;
      1: v = 16'h8000;
      2: v = 16'h7fff;
      3: v = 16'(int'($urandom_range(200)) - 100);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic tmbt_pkg::tmbt_in_t vel_word(input int s, input int w, input int h,
                                                  input int r, input int y);
    tmbt_pkg::tmbt_in_t x;
    x.op        = tmbt_pkg::OP_VELOCITY;
    x.surge     = s[15:0];
    x.sway      = w[15:0];
    x.heave     = h[15:0];
    x.roll_axis = r[15:0];
    x.yaw_axis  = y[15:0];
    x.buttons   = 17'($urandom);  // ignored by a velocity word
    return x;
  endfunction

  function automatic tmbt_pkg::tmbt_in_t btn_word(input logic [tmbt_pkg::BTN_W-1:0] b);
    tmbt_pkg::tmbt_in_t x;
    x.op        = tmbt_pkg::OP_BUTTONS;
    x.surge     = rand_axis();  // axes ignored by a button word
    x.sway      = rand_axis();
    x.heave     = rand_axis();
    x.roll_axis = rand_axis();
    x.yaw_axis  = rand_axis();
    x.buttons   = b;
    return x;
  endfunction

  // random mix of velocity words, button noise and gain walks
  task automatic queue_random(input int cnt);
    int                         added;
    int                         steps;
    logic [tmbt_pkg::BTN_W-1:0] other;
    int unsigned                gbit;
    added = 0;
    while (added < cnt) begin
      case ($urandom_range(9))
        0: begin
          // press and release one gain button several times in a row
          steps = $urandom_range(4, 9);
          gbit  = $urandom_range(1) ? tmbt_pkg::BTN_GAIN_UP : tmbt_pkg::BTN_GAIN_DN;
          for (int k = 0; k < steps; k++) begin
            other = 17'($urandom);
            other[tmbt_pkg::BTN_GAIN_UP] = 1'b0;
            other[tmbt_pkg::BTN_GAIN_DN] = 1'b0;
            stim_put(btn_word(other | (17'd1 << gbit)));
            stim_put(btn_word(other & 17'($urandom)));
            added += 2;
          end
        end
        1, 2, 3: begin
          stim_put(btn_word(17'($urandom)));
          added++;
        end
        default: begin
          stim_put(vel_word($signed(rand_axis()), $signed(rand_axis()),
                            $signed(rand_axis()), $signed(rand_axis()),
                            $signed(rand_axis())));
          added++;
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    while (stim_q.size() != 0 || in_ch.valid || due_words.size() != 0) @(posedge clk);
  endtask

  // stimulus sequence and end of run
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero sum, press held from reset, both gain buttons at once
    stim_put(vel_word(0, 0, 0, 0, 0));
    stim_put(btn_word('1));
    stim_put(btn_word('0));
    stim_put(btn_word('1));
    stim_put(btn_word('0));
    // gain up to the cap and one press beyond it
    for (int i = 0; i < 6; i++) begin
      stim_put(btn_word(17'd1 << tmbt_pkg::BTN_GAIN_UP));
      stim_put(btn_word('0));
    end
    // full negative heave and roll at top gain saturates
    stim_put(vel_word(0, 0, -32768, -32768, 0));
    stim_put(vel_word(-32768, -32768, -32768, -32768, -32768));
    stim_put(vel_word(32767, 32767, 32767, 32767, 32767));
    stim_put(vel_word(32767, -32768, 32767, -32768, 1));
    stim_put(btn_word(17'd1 << tmbt_pkg::BTN_GAIN_DN));
    stim_put(btn_word('0));
    wait_drained();

    // random with idling on both sides, long output stall lands here
    queue_random(400);
    while (stim_q.size() != 0) @(posedge clk);

    // stretch with no idling
    calm = 1'b1;
    queue_random(300);
    while (stim_q.size() != 0) @(posedge clk);
    calm = 1'b0;

    queue_random(329);
    wait_drained();
    repeat (TAIL) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
